/* hw/rtl/gbn_pkg.sv */
// Shared types, field widths and codes for the go-back-n sender window.
// No dependencies; every other file imports this package.
`default_nettype none
package gbn_pkg;

  localparam int SEQ_BITS   = 3;
  localparam int SLOT_BITS  = SEQ_BITS - 1;
  localparam int WIN_SLOTS  = 1 << SLOT_BITS;

  localparam int KIND_W     = 2;
  localparam int DATA_W     = 64;
  localparam int SEQ_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int TIMER_W    = 32;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(20);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input kinds
  localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_SENT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACK     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CORRUPT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESEND  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd6;

  // work handed from front to back; count is the resend burst length
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEQ_BITS-1:0] seq;
    logic [DATA_W-1:0]   data;
    logic [SEQ_BITS-1:0] count;
    logic [SEQ_BITS-1:0] base;
    logic [SEQ_BITS-1:0] next;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/gbn_if.sv */
// Valid/ready channel interfaces: request, response and timeout config.
// Depends on gbn_pkg for field widths.
`default_nettype none
interface gbn_req_if import gbn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [DATA_W-1:0]   payload;
  logic [SEQ_W-1:0]    ack_number;
  logic                ack_checksum_ok;

  modport source(output valid, kind, payload, ack_number, ack_checksum_ok, input ready);
  modport sink(input valid, kind, payload, ack_number, ack_checksum_ok, output ready);
endinterface

interface gbn_rsp_if import gbn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SEQ_W-1:0]    seq_number;
  logic [DATA_W-1:0]   packet_data;
  logic                last;
  logic [SEQ_W-1:0]    window_base;
  logic [SEQ_W-1:0]    next_sequence;

  modport source(output valid, status, seq_number, packet_data, last, window_base,
                 next_sequence, input ready);
  modport sink(input valid, status, seq_number, packet_data, last, window_base,
               next_sequence, output ready);
endinterface

interface gbn_cfg_if import gbn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIMER_W-1:0] timeout_ticks;

  modport source(output valid, timeout_ticks, input ready);
  modport sink(input valid, timeout_ticks, output ready);
endinterface
`default_nettype wire

/* hw/rtl/gbn_front.sv */
// Front end: accepts requests, owns window pointers, timer and timeout register,
// and pushes one command per item into the queue. Depends on gbn_pkg, gbn_if.
`default_nettype none
module gbn_front import gbn_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  gbn_req_if.sink      req,
  gbn_cfg_if.sink      cfg,
  input  wire q_stat_t q_stat,
  output logic         push,
  output cmd_t         cmd
);

  logic [SEQ_BITS-1:0]  base_seq, base_seq_next;
  logic [SEQ_BITS-1:0]  next_seq, next_seq_next;
  logic                 timer_running, timer_running_next;
  logic [TIMER_W-1:0]   timer_count, timer_count_next;
  logic [TIMER_W-1:0]   timeout_ticks;

  logic [SEQ_BITS-1:0]  seq_inc;
  logic [SLOT_BITS-1:0] b, s, a;
  logic                 in_window;
  logic [TIMER_W-1:0]   count_inc;

  assign req.ready = !q_stat.full;
  assign cfg.ready = 1'b1;
  assign push      = req.valid && !q_stat.full;

  assign seq_inc   = next_seq + SEQ_BITS'(1);
  assign b         = base_seq[SLOT_BITS-1:0];
  assign s         = next_seq[SLOT_BITS-1:0];
  assign a         = req.ack_number[SLOT_BITS-1:0];
  assign in_window = (b > s) ? ((a >= b) || (a < s)) : ((a >= b) && (a < s));
  assign count_inc = timer_count + TIMER_W'(1);

  always_comb begin
    base_seq_next      = base_seq;
    next_seq_next      = next_seq;
    timer_running_next = timer_running;
    timer_count_next   = timer_count;
    cmd.status         = ST_IDLE;
    cmd.seq            = '0;
    cmd.data           = '0;
    cmd.count          = '0;
    unique case (req.kind)
      KIND_SEND: begin
        if (seq_inc[SLOT_BITS-1:0] == b) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.status    = ST_SENT;
          cmd.seq       = next_seq;
          cmd.data      = req.payload;
          next_seq_next = seq_inc;
          if (base_seq == next_seq) begin
            timer_running_next = 1'b1;
            timer_count_next   = '0;
          end
        end
      end
      KIND_ACK: begin
        if (!req.ack_checksum_ok) begin
          cmd.status = ST_CORRUPT;
        end else if (!in_window) begin
          cmd.status = ST_OUTSIDE;
        end else begin
          cmd.status    = ST_ACK;
          base_seq_next = base_seq + SEQ_BITS'(SLOT_BITS'(a - b)) + SEQ_BITS'(1);
          // keep the timer only while packets remain outstanding
          timer_running_next = (base_seq_next != next_seq);
          timer_count_next   = '0;
        end
      end
      KIND_TICK: begin
        if (timer_running) begin
          if (count_inc >= timeout_ticks) begin
            timer_count_next = '0;
            if (next_seq != base_seq) begin
              cmd.status = ST_RESEND;
              cmd.seq    = base_seq;
              cmd.count  = next_seq - base_seq;
            end
          end else begin
            timer_count_next = count_inc;
          end
        end
      end
      default: begin
      end
    endcase
    cmd.base = base_seq_next;
    cmd.next = next_seq_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq      <= '0;
      next_seq      <= '0;
      timer_running <= 1'b0;
      timer_count   <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else begin
      if (push) begin
        base_seq      <= base_seq_next;
        next_seq      <= next_seq_next;
        timer_running <= timer_running_next;
        timer_count   <= timer_count_next;
      end
      if (cfg.valid) begin
        timeout_ticks <= cfg.timeout_ticks;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gbn_queue.sv */
// Short command FIFO between the front end and the back end.
// Depends on gbn_pkg for cmd_t and queue sizing.
`default_nettype none
module gbn_queue import gbn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  input  wire logic  pop,
  output cmd_t       head,
  output q_stat_t    q_stat
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gbn_back.sv */
// Back end: holds the payload ring, expands resend bursts and drives the
// registered response channel. Depends on gbn_pkg, gbn_if.
`default_nettype none
module gbn_back import gbn_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cmd_t    head,
  input  wire q_stat_t q_stat,
  output logic         pop,
  gbn_rsp_if.source    rsp
);

  logic [DATA_W-1:0]   store [WIN_SLOTS];

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SEQ_BITS-1:0] out_seq;
  logic [DATA_W-1:0]   out_data;
  logic                out_last;
  logic [SEQ_BITS-1:0] out_base;
  logic [SEQ_BITS-1:0] out_next;

  logic                burst;
  logic [SEQ_BITS-1:0] cursor;
  logic [SEQ_BITS-1:0] remaining;
  logic [SEQ_BITS-1:0] burst_base;
  logic [SEQ_BITS-1:0] burst_next;

  logic                load_ok;
  logic                head_multi;

  assign load_ok    = !out_valid || rsp.ready;
  assign pop        = !burst && !q_stat.empty && load_ok;
  assign head_multi = (head.status == ST_RESEND) && (head.count != SEQ_BITS'(1));

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.seq_number    = SEQ_W'(out_seq);
  assign rsp.packet_data   = out_data;
  assign rsp.last          = out_last;
  assign rsp.window_base   = SEQ_W'(out_base);
  assign rsp.next_sequence = SEQ_W'(out_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      burst     <= 1'b0;
    end else if (load_ok) begin
      if (burst) begin
        out_valid <= 1'b1;
        if (remaining == SEQ_BITS'(1)) begin
          burst <= 1'b0;
        end
      end else if (!q_stat.empty) begin
        out_valid <= 1'b1;
        burst     <= head_multi;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (burst) begin
        out_status <= ST_RESEND;
        out_seq    <= cursor;
        out_data   <= store[cursor[SLOT_BITS-1:0]];
        out_last   <= (remaining == SEQ_BITS'(1));
        out_base   <= burst_base;
        out_next   <= burst_next;
        cursor     <= cursor + SEQ_BITS'(1);
        remaining  <= remaining - SEQ_BITS'(1);
      end else if (!q_stat.empty) begin
        out_status <= head.status;
        out_seq    <= head.seq;
        out_data   <= (head.status == ST_RESEND) ? store[head.seq[SLOT_BITS-1:0]]
                                                 : head.data;
        out_last   <= !head_multi;
        out_base   <= head.base;
        out_next   <= head.next;
        // first resend goes out now, the rest follow from the cursor
        cursor     <= head.seq + SEQ_BITS'(1);
        remaining  <= head.count - SEQ_BITS'(1);
        burst_base <= head.base;
        burst_next <= head.next;
        if (head.status == ST_SENT) begin
          store[head.seq[SLOT_BITS-1:0]] <= head.data;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/go_back_n_sender_window_core.sv */
// Top level of the go-back-n sender window: front end, command queue, back end.
// Depends on gbn_pkg, gbn_if, gbn_front, gbn_queue, gbn_back.
//
//   channel  dir  handshake    content
//   req      in   valid/ready  kind, payload, ack_number, ack_checksum_ok
//   rsp      out  valid/ready  status, seq_number, packet_data, last, bases
//   cfg      in   valid/ready  timeout_ticks (always ready)
//
// Sends, acks and ticks are taken one per cycle while the two-entry queue
// has room; an item is written into the queue on acceptance and can leave it
// only once it has been written, and its result is registered at the edge it leaves.
// A timeout emits one resend per outstanding packet, one per cycle while rsp is
// ready, from the single registered response stage; meanwhile the queue takes up
// to two more items, then req.ready drops until the burst ends.
// Reset is synchronous; it empties the window, stops the timer, sets the
// timeout to 20 and clears the queue. A stalled rsp holds its item and fills
// the queue, after which req.ready drops.
`default_nettype none
module go_back_n_sender_window_core import gbn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  gbn_req_if.sink    req,
  gbn_cfg_if.sink    cfg,
  gbn_rsp_if.source  rsp
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    cmd;
  cmd_t    head;

  gbn_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cfg    (cfg),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (cmd)
  );

  gbn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  gbn_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .rsp    (rsp)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("command queue read while empty");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_RESEND |-> rsp.last)
    else $error("single result without last");

  a_no_packet: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_RESEND && rsp.status != ST_SENT
      |-> rsp.seq_number == '0 && rsp.packet_data == '0)
    else $error("packet fields set on a result without packet");
`endif

endmodule
`default_nettype wire

/* tb/go_back_n_sender_window_core_test.sv */
// Self-checking testbench for the go-back-n sender window core.
// Depends on gbn_pkg, the gbn_if channel interfaces and the core RTL.
// A window scoreboard predicts every result item from the accepted requests.
`default_nettype none
module go_back_n_sender_window_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned HOLD_CYCLES    = 48;
  localparam int unsigned PHASE_ITEMS    = 19;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq_number;
    logic [DATA_W-1:0]   packet_data;
    logic                last;
    logic [SEQ_W-1:0]    window_base;
    logic [SEQ_W-1:0]    next_sequence;
  } window_result_t;

  class gbn_window_scoreboard;
    logic [TIMER_W-1:0]  timeout;
    logic [SEQ_BITS-1:0] base;
    logic [SEQ_BITS-1:0] next;
    logic [DATA_W-1:0]   slots [WIN_SLOTS];
    bit                  timer_on;
    logic [TIMER_W-1:0]  ticks;
    window_result_t      expected [$];
    int                  errors;

    function new();
      timeout  = TIMEOUT_RESET;
      base     = '0;
      next     = '0;
      timer_on = 1'b0;
      ticks    = '0;
      errors   = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void set_timeout(logic [TIMER_W-1:0] value);
      timeout = value;
    endfunction

    function logic [SEQ_BITS-1:0] outstanding();
      return next - base;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void restart_timer();
      timer_on = 1'b1;
      ticks    = '0;
    endfunction

    function void push(logic [STATUS_W-1:0] status, logic [SEQ_BITS-1:0] seq,
                       logic [DATA_W-1:0] data, logic last);
      window_result_t r;
      r.status        = status;
      r.seq_number    = SEQ_W'(seq);
      r.packet_data   = data;
      r.last          = last;
      r.window_base   = SEQ_W'(base);
      r.next_sequence = SEQ_W'(next);
      expected.push_back(r);
    endfunction

    function void note_input(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] payload,
                             logic [SEQ_W-1:0] ack, logic ack_ok);
      logic [SLOT_BITS-1:0] b, s, a, offset;
      logic [SEQ_BITS-1:0]  seq, n;
      bit                   inside_win;
      b = base[SLOT_BITS-1:0];
      s = next[SLOT_BITS-1:0];
      a = ack[SLOT_BITS-1:0];
      case (kind)
        KIND_SEND: begin
          if (SLOT_BITS'(next + 1'b1) == b) begin
            push(ST_FULL, '0, '0, 1'b1);
          end else begin
            slots[s] = payload;
            if (base == next) restart_timer();
            seq  = next;
            next = next + 1'b1;
            push(ST_SENT, seq, payload, 1'b1);
          end
        end
        KIND_ACK: begin
          if (!ack_ok) begin
            push(ST_CORRUPT, '0, '0, 1'b1);
          end else begin
            if (b > s) inside_win = (a >= b) || (a < s);
            else inside_win = (a >= b) && (a < s);
            if (!inside_win) begin
              push(ST_OUTSIDE, '0, '0, 1'b1);
            end else begin
              offset = a - b;
              base = base + SEQ_BITS'(offset) + 1'b1;
              if (base != next) begin
                restart_timer();
              end else begin
                timer_on = 1'b0;
                ticks    = '0;
              end
              push(ST_ACK, '0, '0, 1'b1);
            end
          end
        end
        KIND_TICK: begin
          if (timer_on && (ticks + 1'b1 >= timeout)) begin
            n = next - base;
            restart_timer();
            if (n == 0) begin
              push(ST_IDLE, '0, '0, 1'b1);
            end else begin
              for (int i = 0; i < n; i++) begin
                seq = base + SEQ_BITS'(i);
                push(ST_RESEND, seq, slots[seq[SLOT_BITS-1:0]], i == n - 1);
              end
            end
          end else begin
            if (timer_on) ticks = ticks + 1'b1;
            push(ST_IDLE, '0, '0, 1'b1);
          end
        end
        default: push(ST_IDLE, '0, '0, 1'b1);
      endcase
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] exp_val,
                                logic [DATA_W-1:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(window_result_t got);
      window_result_t want;
      if (expected.size() == 0) begin
        $error("result item with nothing expected: status %0d seq %0d", got.status,
               got.seq_number);
        errors++;
        return;
      end
      want = expected.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("seq_number", want.seq_number, got.seq_number);
      compare_field("packet_data", want.packet_data, got.packet_data);
      compare_field("last", want.last, got.last);
      compare_field("window_base", want.window_base, got.window_base);
      compare_field("next_sequence", want.next_sequence, got.next_sequence);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   tx_eager;
  bit   rx_eager;
  bit   hold_req;
  int unsigned idle_cycles;

  gbn_window_scoreboard sb;

  gbn_req_if req_ch ();
  gbn_cfg_if cfg_ch ();
  gbn_rsp_if rsp_ch ();

  go_back_n_sender_window_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .cfg (cfg_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // track accepted items and predict or check at each edge
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (req_ch.valid && req_ch.ready)
        sb.note_input(req_ch.kind, req_ch.payload, req_ch.ack_number,
                      req_ch.ack_checksum_ok);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result({rsp_ch.status, rsp_ch.seq_number, rsp_ch.packet_data,
                         rsp_ch.last, rsp_ch.window_base, rsp_ch.next_sequence});
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      int unsigned stall;
      @(negedge clk);
      stall = rx_eager ? 0 : $urandom_range(0, 3);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  task automatic wait_gap();
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drive_req(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] payload,
                           logic [SEQ_W-1:0] ack, logic ack_ok);
    req_ch.kind            = kind;
    req_ch.payload         = payload;
    req_ch.ack_number      = ack;
    req_ch.ack_checksum_ok = ack_ok;
    req_ch.valid           = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic put_item(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] payload,
                          logic [SEQ_W-1:0] ack, logic ack_ok);
    wait_gap();
    drive_req(kind, payload, ack, ack_ok);
  endtask

  // mostly well-formed traffic: in-window acks, sends and ticks; some noise
  task automatic offer_random();
    int unsigned          pick;
    logic [KIND_W-1:0]    kind;
    logic [DATA_W-1:0]    payload;
    logic [SEQ_W-1:0]     ack;
    logic                 ack_ok;
    logic [SEQ_BITS-1:0]  outstanding;
    wait_gap();
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       payload = '0;
      1:       payload = '1;
      default: payload = {$urandom, $urandom};
    endcase
    ack         = SEQ_W'($urandom_range(0, 127));
    ack_ok      = $urandom_range(0, 9) != 0;
    outstanding = sb.outstanding();
    if (pick < 40) begin
      kind = KIND_SEND;
    end else if (pick < 70) begin
      kind = KIND_ACK;
      if (outstanding != 0 && $urandom_range(0, 4) != 0)
        ack[SLOT_BITS-1:0] = SLOT_BITS'(sb.base + $urandom_range(0, outstanding - 1));
    end else if (pick < 95) begin
      kind = KIND_TICK;
    end else begin
      kind = KIND_SPARE;
    end
    drive_req(kind, payload, ack, ack_ok);
  endtask

  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(logic [TIMER_W-1:0] value);
    @(negedge clk);
    cfg_ch.timeout_ticks = value;
    cfg_ch.valid         = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_timeout(value);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic random_phase(logic [TIMER_W-1:0] timeout, bit tx_fast, bit rx_fast,
                              bit long_hold);
    write_timeout(timeout);
    tx_eager = tx_fast;
    rx_eager = rx_fast;
    hold_req = long_hold;
    repeat (PHASE_ITEMS) offer_random();
    settle();
  endtask

  initial begin
    sb                     = new();
    rst                    = 1'b1;
    tx_eager               = 1'b0;
    rx_eager               = 1'b0;
    hold_req               = 1'b0;
    req_ch.valid           = 1'b0;
    req_ch.kind            = KIND_SEND;
    req_ch.payload         = '0;
    req_ch.ack_number      = '0;
    req_ch.ack_checksum_ok = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.timeout_ticks   = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: empty window, full window, bad acks, expiry and wrap-around
    write_timeout(TIMER_W'(2));
    put_item(KIND_ACK, '0, 7'h00, 1'b1);
    put_item(KIND_TICK, '0, '0, 1'b0);
    put_item(KIND_SPARE, '1, 7'h7F, 1'b1);
    put_item(KIND_SEND, '0, '0, 1'b0);
    put_item(KIND_SEND, '1, '1, 1'b1);
    put_item(KIND_SEND, {$urandom, $urandom}, '0, 1'b0);
    put_item(KIND_SEND, {$urandom, $urandom}, '0, 1'b0);
    put_item(KIND_ACK, '0, 7'h00, 1'b0);
    put_item(KIND_ACK, '0, 7'h7F, 1'b1);
    put_item(KIND_TICK, '0, '0, 1'b0);
    put_item(KIND_TICK, '0, '0, 1'b0);
    put_item(KIND_ACK, '0, 7'h7C, 1'b1);
    put_item(KIND_ACK, '0, 7'h7E, 1'b1);
    repeat (4) put_item(KIND_SEND, {$urandom, $urandom}, '0, 1'b0);
    put_item(KIND_ACK, '0, 7'h05, 1'b1);
    repeat (3) put_item(KIND_SEND, {$urandom, $urandom}, '0, 1'b0);
    put_item(KIND_ACK, '0, 7'h03, 1'b1);
    repeat (2) put_item(KIND_TICK, '0, '0, 1'b0);
    settle();

    random_phase(TIMER_W'(1), 1'b1, 1'b1, 1'b0);
    random_phase('1, 1'b0, 1'b0, 1'b1);
    random_phase(TIMER_W'(3), 1'b0, 1'b1, 1'b0);
    random_phase(TIMER_W'(20), 1'b0, 1'b0, 1'b0);

    if (sb.pending() != 0) begin
      $error("%0d expected result items never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
